// ===== sv/rrs_pkg.sv =====
package rrs_pkg;

  // input opcodes
  localparam logic [2:0] OP_JOIN      = 3'd0;
  localparam logic [2:0] OP_SCHEDULE  = 3'd1;
  localparam logic [2:0] OP_LOC_REQ   = 3'd2;
  localparam logic [2:0] OP_LOC_REPLY = 3'd3;
  localparam logic [2:0] OP_MOVE      = 3'd4;
  localparam logic [2:0] OP_RES_REQ   = 3'd5;
  localparam logic [2:0] OP_RES_GRANT = 3'd6;
  localparam logic [2:0] OP_REMOVE    = 3'd7;

  // result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_DUPLICATE   = 3'd1;
  localparam logic [2:0] ST_NOT_CURRENT = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [2:0] ST_FULL        = 3'd4;
  localparam logic [2:0] ST_NONE_READY  = 3'd5;

  // notification kinds
  localparam logic [2:0] NK_NONE     = 3'd0;
  localparam logic [2:0] NK_JOINED   = 3'd1;
  localparam logic [2:0] NK_MOVE     = 3'd2;
  localparam logic [2:0] NK_RES_REQ  = 3'd3;
  localparam logic [2:0] NK_LOC_REQ  = 3'd4;
  localparam logic [2:0] NK_GRANTED  = 3'd5;
  localparam logic [2:0] NK_REMOVED  = 3'd6;

  // configuration register indexes
  localparam logic [7:0] CFG_QUANTUM = 8'd0;
  localparam logic [7:0] CFG_POLICY  = 8'd1;

  localparam int TURN_BITS = 9;
  localparam logic [TURN_BITS-1:0] TURN_MAX = 9'd511;

  // ready list command
  typedef struct packed {
    logic wr;   // write one entry
    logic rot;  // rotate head to tail
  } rl_cmd_t;

endpackage

// ===== sv/rrs_dist_unit.sv =====
module rrs_dist_unit #(
  parameter int COORD_BITS = 8,
  parameter int DW         = 9
) (
  input  logic [COORD_BITS-1:0] pos_x,
  input  logic [COORD_BITS-1:0] pos_y,
  input  logic [COORD_BITS-1:0] tgt_x,
  input  logic [COORD_BITS-1:0] tgt_y,
  input  logic                  has_target,
  input  logic [7:0]            quantum,
  output logic [DW-1:0]         distance
);

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;

  assign dx = (pos_x > tgt_x) ? (pos_x - tgt_x) : (tgt_x - pos_x);
  assign dy = (pos_y > tgt_y) ? (pos_y - tgt_y) : (tgt_y - pos_y);

  // Manhattan distance, quantum stands in when no target is known
  assign distance = has_target ? (DW'(dx) + DW'(dy)) : DW'(quantum);

endmodule

// ===== sv/rrs_ready_list.sv =====
module rrs_ready_list #(
  parameter int MAX_ENTRIES = 16,
  parameter int IW          = 4,
  parameter int KW          = 5
) (
  input  logic           clk,
  input  rrs_pkg::rl_cmd_t cmd,
  input  logic [KW-1:0]  count,
  input  logic [IW-1:0]  rd_idx,
  output logic [IW-1:0]  rd_data,
  input  logic [IW-1:0]  wr_idx,
  input  logic [IW-1:0]  wr_data
);

  logic [IW-1:0] order [MAX_ENTRIES];

  assign rd_data = order[rd_idx];

  always_ff @(posedge clk) begin
    if (cmd.rot) begin
      // shift each live entry down one place, old head to the tail
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (KW'(i) + KW'(1) < count) begin
          order[i] <= order[(i + 1) % MAX_ENTRIES];
        end else if (KW'(i) + KW'(1) == count) begin
          order[i] <= order[0];
        end
      end
    end else if (cmd.wr) begin
      order[wr_idx] <= wr_data;
    end
  end

endmodule

// ===== sv/rr_srdf_turn_scheduler_unit.sv =====
// Channel   Direction  Handshake               Payload
// s_*       in         s_tvalid / s_tready     one request item
// m_*       out        m_tvalid / m_tready     one result item per request
// cfg_*     in         cfg_valid / cfg_ready   register write (index, data)
//
// Walks: single-step opcodes need no walk; join and resource granted walk all
//   MAX_ENTRIES slots, one a cycle; remove walks the slots and then the ready list
//   to compact it; resource request compacts the ready list only; shortest-distance
//   scheduling walks the ready list through the distance unit.
// Reset: rst clears control state and valid bits; slot payload stays unset.
// Stalls: s_tready is high only while idle; a finished result holds in the
//   output register until taken, and the next item may enter meanwhile.
module rr_srdf_turn_scheduler_unit #(
  parameter int MAX_ENTRIES = 16,
  parameter int COORD_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // symbol, coord_x, coord_y, resource_id
  input  logic [2:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // status, turn_granted, turn_symbol,
                                 // turns_granted, notify_symbol,
                                 // notify_resource, scheduler_empty, zero pad
  output logic [2:0]  m_tuser,   // notify_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int KW = $clog2(MAX_ENTRIES + 1);
  localparam int DW = (COORD_BITS + 1 > rrs_pkg::TURN_BITS) ? COORD_BITS + 1
                                                            : rrs_pkg::TURN_BITS;
  localparam int TB = rrs_pkg::TURN_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_JOIN = 3'd2;
  localparam logic [2:0] S_SRDF = 3'd3;
  localparam logic [2:0] S_FIND = 3'd4;
  localparam logic [2:0] S_DROP = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state;

  // configuration
  logic [7:0] quantum;
  logic       policy;

  // latched request
  logic [2:0]            op;
  logic [7:0]            sym;
  logic [COORD_BITS-1:0] cx;
  logic [COORD_BITS-1:0] cy;
  logic [7:0]            res;

  // client table
  logic [7:0]            slot_symbol   [MAX_ENTRIES];
  logic [COORD_BITS-1:0] slot_pos_x    [MAX_ENTRIES];
  logic [COORD_BITS-1:0] slot_pos_y    [MAX_ENTRIES];
  logic [COORD_BITS-1:0] slot_target_x [MAX_ENTRIES];
  logic [COORD_BITS-1:0] slot_target_y [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] slot_has_target;
  logic [MAX_ENTRIES-1:0] slot_used;
  logic [MAX_ENTRIES-1:0] blocked_mark;

  logic [KW-1:0] ready_count;
  logic [IW-1:0] cur_slot;
  logic [7:0]    cur_sym;
  logic          cur_valid;
  logic [TB-1:0] turns;
  logic          loc_asked;

  // walk state
  logic [KW-1:0] k;
  logic [KW-1:0] w;
  logic          found;
  logic          dup;
  logic [IW-1:0] fslot;
  logic [IW-1:0] drop_slot;
  logic [IW-1:0] best;
  logic [7:0]    best_sym;
  logic [DW-1:0] best_dist;

  // result fields
  logic [2:0] r_status;
  logic       r_granted;
  logic [2:0] r_nkind;
  logic [7:0] r_nsym;
  logic [7:0] r_nres;

  // output register
  logic [2:0]    o_status;
  logic          o_granted;
  logic [7:0]    o_tsym;
  logic [TB-1:0] o_turns;
  logic [2:0]    o_nkind;
  logic [7:0]    o_nsym;
  logic [7:0]    o_nres;
  logic          o_empty;

  // ready list port
  rrs_pkg::rl_cmd_t rl_cmd;
  logic [IW-1:0]    rl_rd_idx;
  logic [IW-1:0]    rl_rd_data;
  logic [IW-1:0]    rl_wr_idx;
  logic [IW-1:0]    rl_wr_data;

  rrs_ready_list #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .IW          (IW),
    .KW          (KW)
  ) u_ready (
    .clk     (clk),
    .cmd     (rl_cmd),
    .count   (ready_count),
    .rd_idx  (rl_rd_idx),
    .rd_data (rl_rd_data),
    .wr_idx  (rl_wr_idx),
    .wr_data (rl_wr_data)
  );

  // slot read address: table index during lookups, ready entry otherwise
  logic [IW-1:0] sl_rd;
  logic [IW-1:0] k_idx;
  logic          k_last;
  logic          k_in_list;
  logic [7:0]    sl_sym;
  logic [DW-1:0] route_dist;

  assign k_idx     = k[IW-1:0];
  assign k_last    = (k == KW'(MAX_ENTRIES - 1));
  assign k_in_list = (k < ready_count);
  assign sl_rd     = (state == S_FIND) ? k_idx : rl_rd_data;
  assign sl_sym    = slot_symbol[sl_rd];

  rrs_dist_unit #(
    .COORD_BITS (COORD_BITS),
    .DW         (DW)
  ) u_dist (
    .pos_x      (slot_pos_x[sl_rd]),
    .pos_y      (slot_pos_y[sl_rd]),
    .tgt_x      (slot_target_x[sl_rd]),
    .tgt_y      (slot_target_y[sl_rd]),
    .has_target (slot_has_target[sl_rd]),
    .quantum    (quantum),
    .distance   (route_dist)
  );

  logic is_cur;
  assign is_cur = cur_valid && (cur_sym == sym);

  // walk decisions for this cycle
  logic          dup_n;
  logic          found_n;
  logic [IW-1:0] fslot_n;
  logic          take_best;
  logic [IW-1:0] best_n;
  logic [7:0]    best_sym_n;
  logic [DW-1:0] best_dist_n;
  logic [TB-1:0] turns_dec;

  always_comb begin
    dup_n   = dup;
    found_n = found;
    fslot_n = fslot;
    if (state == S_JOIN) begin
      if (k_in_list && sl_sym == sym) dup_n = 1'b1;
      if (!slot_used[k_idx] && !found) begin
        found_n = 1'b1;
        fslot_n = k_idx;
      end
    end else begin
      // highest matching slot wins
      if (slot_used[k_idx] && sl_sym == sym &&
          (op == rrs_pkg::OP_REMOVE || blocked_mark[k_idx])) begin
        found_n = 1'b1;
        fslot_n = k_idx;
      end
    end
    take_best   = (k == '0) || (route_dist < best_dist);
    best_n      = take_best ? rl_rd_data : best;
    best_sym_n  = take_best ? sl_sym : best_sym;
    best_dist_n = take_best ? route_dist : best_dist;
    turns_dec   = (turns != '0) ? (turns - TB'(1)) : '0;
  end

  always_comb begin
    rl_cmd     = '0;
    rl_rd_idx  = k_idx;
    rl_wr_idx  = ready_count[IW-1:0];
    rl_wr_data = fslot_n;
    case (state)
      S_EXEC: begin
        rl_rd_idx = (ready_count > KW'(1)) ? IW'(1) : '0;
        rl_cmd.rot = (op == rrs_pkg::OP_SCHEDULE) && !cur_valid &&
                     (ready_count != '0) && !policy;
      end
      S_JOIN: begin
        rl_cmd.wr = k_last && !dup_n && found_n &&
                    (ready_count < KW'(MAX_ENTRIES));
      end
      S_FIND: begin
        rl_cmd.wr = k_last && found_n && (op == rrs_pkg::OP_RES_GRANT) &&
                    (ready_count < KW'(MAX_ENTRIES));
      end
      S_DROP: begin
        rl_wr_idx  = w[IW-1:0];
        rl_wr_data = rl_rd_data;
        rl_cmd.wr  = k_in_list && (rl_rd_data != drop_slot);
      end
      default: begin
      end
    endcase
  end

  logic any_blocked;
  assign any_blocked = |(slot_used & blocked_mark);

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      quantum         <= 8'd3;
      policy          <= 1'b0;
      slot_has_target <= '0;
      slot_used       <= '0;
      blocked_mark    <= '0;
      ready_count     <= '0;
      cur_slot        <= '0;
      cur_sym         <= '0;
      cur_valid       <= 1'b0;
      turns           <= '0;
      loc_asked       <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == rrs_pkg::CFG_QUANTUM) quantum <= cfg_data;
        else if (cfg_index == rrs_pkg::CFG_POLICY) policy <= cfg_data[0];
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op        <= s_tuser;
            sym       <= s_tdata[7:0];
            cx        <= COORD_BITS'(s_tdata[15:8]);
            cy        <= COORD_BITS'(s_tdata[23:16]);
            res       <= s_tdata[31:24];
            k         <= '0;
            w         <= '0;
            found     <= 1'b0;
            dup       <= 1'b0;
            r_status  <= rrs_pkg::ST_OK;
            r_granted <= 1'b0;
            r_nkind   <= rrs_pkg::NK_NONE;
            r_nsym    <= '0;
            r_nres    <= '0;
            state     <= S_EXEC;
          end
        end

        S_EXEC: begin
          state <= S_DONE;
          case (op)
            rrs_pkg::OP_JOIN: state <= S_JOIN;
            rrs_pkg::OP_SCHEDULE: begin
              // ignore while a turn is held
              if (!cur_valid) begin
                loc_asked <= 1'b0;
                if (ready_count == '0) begin
                  r_status <= rrs_pkg::ST_NONE_READY;
                end else if (!policy) begin
                  cur_slot  <= rl_rd_data;
                  cur_sym   <= sl_sym;
                  cur_valid <= 1'b1;
                  turns     <= TB'(quantum);
                  r_granted <= 1'b1;
                end else begin
                  state <= S_SRDF;
                end
              end
            end
            rrs_pkg::OP_LOC_REQ: begin
              if (!is_cur) begin
                r_status <= rrs_pkg::ST_NOT_CURRENT;
              end else begin
                loc_asked <= 1'b1;
                r_nkind   <= rrs_pkg::NK_LOC_REQ;
                r_nsym    <= sym;
                r_nres    <= res;
              end
            end
            rrs_pkg::OP_LOC_REPLY: begin
              if (!cur_valid || !loc_asked) begin
                r_status <= rrs_pkg::ST_NOT_CURRENT;
              end else begin
                slot_target_x[cur_slot]   <= cx;
                slot_target_y[cur_slot]   <= cy;
                slot_has_target[cur_slot] <= 1'b1;
                r_granted                 <= 1'b1;
              end
            end
            rrs_pkg::OP_MOVE: begin
              if (!is_cur) begin
                r_status <= rrs_pkg::ST_NOT_CURRENT;
              end else begin
                slot_pos_x[cur_slot] <= cx;
                slot_pos_y[cur_slot] <= cy;
                r_nkind              <= rrs_pkg::NK_MOVE;
                r_nsym               <= sym;
                turns                <= turns_dec;
                // release the turn once it runs out
                if (turns_dec != '0) r_granted <= 1'b1;
                else cur_valid <= 1'b0;
              end
            end
            rrs_pkg::OP_RES_REQ: begin
              if (!is_cur) begin
                r_status <= rrs_pkg::ST_NOT_CURRENT;
              end else begin
                r_nkind                <= rrs_pkg::NK_RES_REQ;
                r_nsym                 <= sym;
                r_nres                 <= res;
                blocked_mark[cur_slot] <= 1'b1;
                cur_valid              <= 1'b0;
                turns                  <= '0;
                drop_slot              <= cur_slot;
                state                  <= S_DROP;
              end
            end
            default: state <= S_FIND;
          endcase
        end

        S_JOIN: begin
          dup   <= dup_n;
          found <= found_n;
          fslot <= fslot_n;
          k     <= k + KW'(1);
          if (k_last) begin
            state <= S_DONE;
            if (dup_n) begin
              r_status <= rrs_pkg::ST_DUPLICATE;
            end else if (!found_n) begin
              r_status <= rrs_pkg::ST_FULL;
            end else begin
              slot_used[fslot_n]       <= 1'b1;
              slot_symbol[fslot_n]     <= sym;
              slot_pos_x[fslot_n]      <= cx;
              slot_pos_y[fslot_n]      <= cy;
              slot_has_target[fslot_n] <= 1'b0;
              blocked_mark[fslot_n]    <= 1'b0;
              if (ready_count < KW'(MAX_ENTRIES)) ready_count <= ready_count + KW'(1);
              r_nkind <= rrs_pkg::NK_JOINED;
              r_nsym  <= sym;
            end
          end
        end

        S_SRDF: begin
          // first minimum in ready order
          best      <= best_n;
          best_sym  <= best_sym_n;
          best_dist <= best_dist_n;
          k         <= k + KW'(1);
          if (k + KW'(1) == ready_count) begin
            cur_slot  <= best_n;
            cur_sym   <= best_sym_n;
            cur_valid <= 1'b1;
            turns     <= (best_dist_n > DW'(rrs_pkg::TURN_MAX)) ? rrs_pkg::TURN_MAX
                                                                : best_dist_n[TB-1:0];
            r_granted <= 1'b1;
            state     <= S_DONE;
          end
        end

        S_FIND: begin
          found <= found_n;
          fslot <= fslot_n;
          k     <= k + KW'(1);
          if (k_last) begin
            state <= S_DONE;
            if (!found_n) begin
              r_status <= rrs_pkg::ST_NOT_FOUND;
            end else if (op == rrs_pkg::OP_RES_GRANT) begin
              blocked_mark[fslot_n]    <= 1'b0;
              slot_has_target[fslot_n] <= 1'b0;
              if (ready_count < KW'(MAX_ENTRIES)) ready_count <= ready_count + KW'(1);
              r_nkind <= rrs_pkg::NK_GRANTED;
              r_nsym  <= sym;
            end else begin
              if (cur_valid && cur_slot == fslot_n) begin
                cur_valid <= 1'b0;
                turns     <= '0;
              end
              blocked_mark[fslot_n]    <= 1'b0;
              slot_used[fslot_n]       <= 1'b0;
              slot_has_target[fslot_n] <= 1'b0;
              r_nkind   <= rrs_pkg::NK_REMOVED;
              r_nsym    <= sym;
              drop_slot <= fslot_n;
              k         <= '0;
              w         <= '0;
              state     <= S_DROP;
            end
          end
        end

        S_DROP: begin
          // compact the ready list, one entry a cycle
          if (k_in_list) begin
            if (rl_rd_data != drop_slot) w <= w + KW'(1);
            k <= k + KW'(1);
          end else begin
            ready_count <= w;
            state       <= S_DONE;
          end
        end

        S_DONE: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            o_status  <= r_status;
            o_granted <= r_granted;
            o_tsym    <= cur_valid ? cur_sym : 8'd0;
            o_turns   <= turns;
            o_nkind   <= r_nkind;
            o_nsym    <= r_nsym;
            o_nres    <= r_nres;
            o_empty   <= (ready_count == '0) && !any_blocked;
            m_tvalid  <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {2'b00, o_empty, o_nres, o_nsym, o_turns, o_tsym, o_granted, o_status};
  assign m_tuser = o_nkind;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    ready_count <= KW'(MAX_ENTRIES))
    else $error("ready count beyond table depth");

  a_cur_used: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> slot_used[cur_slot])
    else $error("current client slot not in use");

  a_no_turns_idle: assert property (@(posedge clk) disable iff (rst)
    !cur_valid |-> (turns == '0))
    else $error("turns left with no current client");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("new item taken while busy");
`endif

endmodule

// ===== tb/rr_srdf_turn_scheduler_unit_test.sv =====
`timescale 1ns / 1ps

module rr_srdf_turn_scheduler_unit_test;

  localparam int SLOTS = 16;
  localparam int RANDOM_ITEMS = 950;
  localparam int CYCLE_LIMIT = 900000;
  // longest request walk plus margin, used before register writes and at the end
  localparam int SETTLE_CYCLES = 2 * SLOTS + 40;

  typedef struct {
    logic [2:0] op;
    logic [7:0] sym;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] res;
  } request_t;

  typedef struct {
    logic [2:0] status;
    logic       granted;
    logic [7:0] turn_sym;
    logic [8:0] turns;
    logic [2:0] nkind;
    logic [7:0] nsym;
    logic [7:0] nres;
    logic       empty;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];
  int       errors = 0;
  int       cycles = 0;

  // scheduler shadow state
  logic [7:0] sh_sym[SLOTS];
  logic [7:0] sh_px[SLOTS];
  logic [7:0] sh_py[SLOTS];
  logic [7:0] sh_tx[SLOTS];
  logic [7:0] sh_ty[SLOTS];
  logic       sh_has_tgt[SLOTS];
  logic       sh_used[SLOTS];
  logic       sh_blocked[SLOTS];
  int         sh_order[SLOTS];
  int         sh_count = 0;
  int         sh_cur = 0;
  logic       sh_cur_valid = 1'b0;
  logic [8:0] sh_turns = '0;
  logic       sh_asked = 1'b0;
  logic [7:0] sh_quantum = 8'd3;
  logic       sh_policy = 1'b0;

  logic [7:0] symbol_pool[20];

  rr_srdf_turn_scheduler_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int route_length(int s);
    int dx, dy;
    if (!sh_has_tgt[s]) return int'(sh_quantum);
    dx = (sh_px[s] > sh_tx[s]) ? int'(sh_px[s]) - int'(sh_tx[s])
                               : int'(sh_tx[s]) - int'(sh_px[s]);
    dy = (sh_py[s] > sh_ty[s]) ? int'(sh_py[s]) - int'(sh_ty[s])
                               : int'(sh_ty[s]) - int'(sh_py[s]);
    return dx + dy;
  endfunction

  // highest-numbered matching slot wins, -1 when none
  function automatic int lookup_slot(logic [7:0] sym, logic need_blocked);
    int found;
    found = -1;
    for (int i = 0; i < SLOTS; i++)
      if (sh_used[i] && sh_sym[i] == sym && (!need_blocked || sh_blocked[i])) found = i;
    return found;
  endfunction

  task automatic unlink_ready(int s);
    int w;
    w = 0;
    for (int i = 0; i < sh_count; i++)
      if (sh_order[i] != s) begin
        sh_order[w] = sh_order[i];
        w++;
      end
    sh_count = w;
  endtask

  // advance the shadow state by one request and queue the outcome it implies
  task automatic schedule_step(request_t r);
    outcome_t e;
    int s, best, bd, d, head;
    logic dup, any_blocked;
    e = '{default: '0};
    s = -1;
    dup = 1'b0;
    any_blocked = 1'b0;
    case (r.op)
      rrs_pkg::OP_JOIN: begin
        for (int i = 0; i < sh_count; i++) if (sh_sym[sh_order[i]] == r.sym) dup = 1'b1;
        if (dup) e.status = rrs_pkg::ST_DUPLICATE;
        else begin
          for (int i = 0; i < SLOTS; i++) if (s < 0 && !sh_used[i]) s = i;
          if (s < 0) e.status = rrs_pkg::ST_FULL;
          else begin
            sh_used[s] = 1'b1;
            sh_sym[s] = r.sym;
            sh_px[s] = r.x;
            sh_py[s] = r.y;
            sh_has_tgt[s] = 1'b0;
            sh_blocked[s] = 1'b0;
            if (sh_count < SLOTS) begin
              sh_order[sh_count] = s;
              sh_count++;
            end
            e.nkind = rrs_pkg::NK_JOINED;
            e.nsym = r.sym;
          end
        end
      end
      rrs_pkg::OP_SCHEDULE: begin
        if (!sh_cur_valid) begin
          sh_asked = 1'b0;
          if (sh_count == 0) e.status = rrs_pkg::ST_NONE_READY;
          else begin
            if (!sh_policy) begin
              head = sh_order[0];
              for (int k = 1; k < sh_count; k++) sh_order[k-1] = sh_order[k];
              sh_order[sh_count-1] = head;
              sh_cur = sh_order[0];
              sh_turns = {1'b0, sh_quantum};
            end else begin
              best = sh_order[0];
              bd = route_length(best);
              for (int k = 1; k < sh_count; k++) begin
                d = route_length(sh_order[k]);
                if (d < bd) begin
                  bd = d;
                  best = sh_order[k];
                end
              end
              sh_cur = best;
              sh_turns = (bd > 511) ? rrs_pkg::TURN_MAX : bd[8:0];
            end
            sh_cur_valid = 1'b1;
            e.granted = 1'b1;
          end
        end
      end
      rrs_pkg::OP_LOC_REQ: begin
        if (!(sh_cur_valid && sh_sym[sh_cur] == r.sym)) e.status = rrs_pkg::ST_NOT_CURRENT;
        else begin
          sh_asked = 1'b1;
          e.nkind = rrs_pkg::NK_LOC_REQ;
          e.nsym = r.sym;
          e.nres = r.res;
        end
      end
      rrs_pkg::OP_LOC_REPLY: begin
        if (!sh_cur_valid || !sh_asked) e.status = rrs_pkg::ST_NOT_CURRENT;
        else begin
          sh_tx[sh_cur] = r.x;
          sh_ty[sh_cur] = r.y;
          sh_has_tgt[sh_cur] = 1'b1;
          e.granted = 1'b1;
        end
      end
      rrs_pkg::OP_MOVE: begin
        if (!(sh_cur_valid && sh_sym[sh_cur] == r.sym)) e.status = rrs_pkg::ST_NOT_CURRENT;
        else begin
          sh_px[sh_cur] = r.x;
          sh_py[sh_cur] = r.y;
          e.nkind = rrs_pkg::NK_MOVE;
          e.nsym = r.sym;
          if (sh_turns > 0) sh_turns--;
          if (sh_turns != 0) e.granted = 1'b1;
          else sh_cur_valid = 1'b0;
        end
      end
      rrs_pkg::OP_RES_REQ: begin
        if (!(sh_cur_valid && sh_sym[sh_cur] == r.sym)) e.status = rrs_pkg::ST_NOT_CURRENT;
        else begin
          e.nkind = rrs_pkg::NK_RES_REQ;
          e.nsym = r.sym;
          e.nres = r.res;
          unlink_ready(sh_cur);
          sh_blocked[sh_cur] = 1'b1;
          sh_cur_valid = 1'b0;
          sh_turns = '0;
        end
      end
      rrs_pkg::OP_RES_GRANT: begin
        s = lookup_slot(r.sym, 1'b1);
        if (s < 0) e.status = rrs_pkg::ST_NOT_FOUND;
        else begin
          sh_blocked[s] = 1'b0;
          sh_has_tgt[s] = 1'b0;
          if (sh_count < SLOTS) begin
            sh_order[sh_count] = s;
            sh_count++;
          end
          e.nkind = rrs_pkg::NK_GRANTED;
          e.nsym = r.sym;
        end
      end
      default: begin
        s = lookup_slot(r.sym, 1'b0);
        if (s < 0) e.status = rrs_pkg::ST_NOT_FOUND;
        else begin
          if (sh_cur_valid && sh_cur == s) begin
            sh_cur_valid = 1'b0;
            sh_turns = '0;
          end
          unlink_ready(s);
          sh_blocked[s] = 1'b0;
          sh_used[s] = 1'b0;
          sh_has_tgt[s] = 1'b0;
          e.nkind = rrs_pkg::NK_REMOVED;
          e.nsym = r.sym;
        end
      end
    endcase
    for (int i = 0; i < SLOTS; i++) if (sh_used[i] && sh_blocked[i]) any_blocked = 1'b1;
    e.turn_sym = sh_cur_valid ? sh_sym[sh_cur] : 8'd0;
    e.turns = sh_turns;
    e.empty = (sh_count == 0) && !any_blocked;
    expected_outcomes.push_back(e);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // request driver: hold an item until taken, then insert a random gap
  int src_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        schedule_step(pending_requests.pop_front());
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= {pending_requests[0].res, pending_requests[0].y,
                      pending_requests[0].x, pending_requests[0].sym};
          s_tuser <= pending_requests[0].op;
          src_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [8:0] want, logic [8:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // result monitor with random back-pressure; a quiet stretch drops the stalls
  int sink_gap = 0;
  int quiet = 0;
  always @(posedge clk) begin
    outcome_t e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_outcomes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item, actual %0h/%0h", $time, m_tdata, m_tuser);
        end else begin
          e = expected_outcomes.pop_front();
          check_field("status", 9'(e.status), 9'(m_tdata[2:0]));
          check_field("turn_granted", 9'(e.granted), 9'(m_tdata[3]));
          check_field("turn_symbol", 9'(e.turn_sym), 9'(m_tdata[11:4]));
          check_field("turns_granted", e.turns, m_tdata[20:12]);
          check_field("notify_symbol", 9'(e.nsym), 9'(m_tdata[28:21]));
          check_field("notify_resource", 9'(e.nres), 9'(m_tdata[36:29]));
          check_field("scheduler_empty", 9'(e.empty), 9'(m_tdata[37]));
          check_field("notify_kind", 9'(e.nkind), 9'(m_tuser));
        end
      end
      if (quiet > 0) quiet--;
      else if ($urandom_range(0, 499) == 0) quiet = $urandom_range(100, 300);
      if (quiet > 0) begin
        m_tready <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        sink_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rr_srdf_turn_scheduler_unit_test failed");
      $finish;
    end
  end

  task automatic push_req(logic [2:0] op, logic [7:0] sym, logic [7:0] x, logic [7:0] y,
                          logic [7:0] res);
    request_t r;
    r.op = op;
    r.sym = sym;
    r.x = x;
    r.y = y;
    r.res = res;
    pending_requests.push_back(r);
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_requests.size() > 0 || s_tvalid || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // wait for a clock edge before raising valid, so each write drives valid anew
  task automatic write_reg(logic [7:0] idx, logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == rrs_pkg::CFG_QUANTUM) sh_quantum = value;
    else sh_policy = value[0];
  endtask

  // one random request shaped by the live state: turn requests mostly name the current client
  task automatic random_request();
    int r, b;
    logic [7:0] sym, x, y;
    logic [7:0] cands[$];
    r = $urandom_range(0, 99);
    sym = symbol_pool[$urandom_range(0, 19)];
    if (sh_cur_valid && $urandom_range(0, 9) < 8) sym = sh_sym[sh_cur];
    x = 8'($urandom);
    y = 8'($urandom);
    // sometimes step close to the target so short routes turn up
    if (sh_cur_valid && sh_has_tgt[sh_cur] && $urandom_range(0, 2) == 0) begin
      x = sh_tx[sh_cur] + 8'($urandom_range(0, 3));
      y = sh_ty[sh_cur];
    end
    if (r < 14) push_req(rrs_pkg::OP_JOIN, symbol_pool[$urandom_range(0, 19)], x, y,
                         8'($urandom));
    else if (r < 30) push_req(rrs_pkg::OP_SCHEDULE, sym, x, y, 8'($urandom));
    else if (r < 40) push_req(rrs_pkg::OP_LOC_REQ, sym, x, y, 8'($urandom));
    else if (r < 50) push_req(rrs_pkg::OP_LOC_REPLY, sym, x, y, 8'($urandom));
    else if (r < 72) push_req(rrs_pkg::OP_MOVE, sym, x, y, 8'($urandom));
    else if (r < 80) push_req(rrs_pkg::OP_RES_REQ, sym, x, y, 8'($urandom));
    else if (r < 92) begin
      for (int i = 0; i < SLOTS; i++) if (sh_used[i] && sh_blocked[i]) cands.push_back(sh_sym[i]);
      b = cands.size();
      if (b > 0 && $urandom_range(0, 3) != 0) sym = cands[$urandom_range(0, b - 1)];
      push_req(rrs_pkg::OP_RES_GRANT, sym, x, y, 8'($urandom));
    end else push_req(rrs_pkg::OP_REMOVE, $urandom_range(0, 4) == 0 ? sym :
                      symbol_pool[$urandom_range(0, 19)], x, y, 8'($urandom));
  endtask

  initial begin
    logic [7:0] q_plan[6];
    q_plan = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd128, 8'd7};
    for (int i = 0; i < 20; i++) symbol_pool[i] = 8'($urandom);
    symbol_pool[0] = 8'h00;
    symbol_pool[1] = 8'hFF;
    for (int i = 0; i < SLOTS; i++) begin
      sh_has_tgt[i] = 1'b0;
      sh_used[i] = 1'b0;
      sh_blocked[i] = 1'b0;
      sh_order[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, every opcode and the named corner cases
    push_req(rrs_pkg::OP_SCHEDULE, 8'h00, 8'h00, 8'h00, 8'h00);   // nothing ready
    push_req(rrs_pkg::OP_JOIN, 8'hA1, 8'h00, 8'h00, 8'h00);
    push_req(rrs_pkg::OP_JOIN, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    push_req(rrs_pkg::OP_JOIN, 8'hFF, 8'h80, 8'h01, 8'h00);
    push_req(rrs_pkg::OP_JOIN, 8'hA1, 8'h10, 8'h10, 8'h00);       // duplicate
    push_req(rrs_pkg::OP_MOVE, 8'hA1, 8'h01, 8'h01, 8'h00);       // nobody holds the turn
    push_req(rrs_pkg::OP_SCHEDULE, 8'h00, 8'h00, 8'h00, 8'h00);
    push_req(rrs_pkg::OP_SCHEDULE, 8'h00, 8'h00, 8'h00, 8'h00);   // turn already held
    push_req(rrs_pkg::OP_LOC_REQ, 8'hA1, 8'h00, 8'h00, 8'h41);    // sender not current
    push_req(rrs_pkg::OP_LOC_REPLY, 8'h00, 8'h05, 8'h05, 8'h00);  // unasked reply
    push_req(rrs_pkg::OP_LOC_REQ, 8'h00, 8'h00, 8'h00, 8'hFF);
    push_req(rrs_pkg::OP_LOC_REPLY, 8'h00, 8'hFF, 8'h00, 8'h00);
    push_req(rrs_pkg::OP_MOVE, 8'h00, 8'hFE, 8'hFF, 8'h00);
    push_req(rrs_pkg::OP_RES_REQ, 8'h00, 8'h00, 8'h00, 8'h00);
    push_req(rrs_pkg::OP_RES_GRANT, 8'hA1, 8'h00, 8'h00, 8'h00);  // not blocked
    push_req(rrs_pkg::OP_RES_GRANT, 8'h00, 8'h00, 8'h00, 8'h00);
    push_req(rrs_pkg::OP_REMOVE, 8'h77, 8'h00, 8'h00, 8'h00);     // unknown symbol
    push_req(rrs_pkg::OP_SCHEDULE, 8'h00, 8'h00, 8'h00, 8'h00);
    push_req(rrs_pkg::OP_MOVE, 8'hFF, 8'h00, 8'h00, 8'h00);
    push_req(rrs_pkg::OP_MOVE, 8'hA1, 8'h00, 8'h00, 8'h00);
    push_req(rrs_pkg::OP_MOVE, 8'h00, 8'h00, 8'h00, 8'h00);
    push_req(rrs_pkg::OP_REMOVE, 8'hA1, 8'h00, 8'h00, 8'h00);
    push_req(rrs_pkg::OP_REMOVE, 8'h00, 8'h00, 8'h00, 8'h00);
    push_req(rrs_pkg::OP_REMOVE, 8'hFF, 8'h00, 8'h00, 8'h00);
    push_req(rrs_pkg::OP_SCHEDULE, 8'h00, 8'h00, 8'h00, 8'h00);
    drain();

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(rrs_pkg::CFG_QUANTUM, ph == 5 ? 8'($urandom) : q_plan[ph]);
      write_reg(rrs_pkg::CFG_POLICY, 8'(ph % 2));
      for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
        while (pending_requests.size() > 0) @(posedge clk);
        #1;
        random_request();
      end
      drain();
    end

    if (errors == 0) begin
      $display("rr_srdf_turn_scheduler_unit_test passed");
    end else begin
      $display("rr_srdf_turn_scheduler_unit_test failed");
    end
    $finish;
  end

endmodule
